FILE: rtl/mp4_sample_table_locator_unit_macros.svh
// Assertion macros shared by the sample table locator RTL.
`ifndef MP4_SAMPLE_TABLE_LOCATOR_UNIT_MACROS_SVH
`define MP4_SAMPLE_TABLE_LOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define MP4STL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mp4stl: assertion failed");

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define MP4STL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mp4stl: assertion failed");

`endif

FILE: rtl/mp4stl_pkg.sv
// Shared constants, codes and types of the sample table locator.
package mp4stl_pkg;

  localparam int unsigned MAP_DEPTH   = 64;
  localparam int unsigned CHUNK_DEPTH = 1024;
  localparam int unsigned SIZE_DEPTH  = 4096;
  localparam int unsigned TIME_DEPTH  = 64;

  localparam int unsigned PAIR_DEPTH = MAP_DEPTH + TIME_DEPTH;
  localparam int unsigned PAIR_AW    = $clog2(PAIR_DEPTH);
  localparam int unsigned WORD_DEPTH = SIZE_DEPTH + CHUNK_DEPTH;
  localparam int unsigned WORD_AW    = $clog2(WORD_DEPTH);
  localparam int unsigned LOOP_IW    =
    $clog2(MAP_DEPTH > TIME_DEPTH ? MAP_DEPTH : TIME_DEPTH);

  localparam logic [31:0] BASE_OFFSET = 32'd8;
  localparam logic [47:0] MAX48       = 48'hFFFF_FFFF_FFFF;

  localparam int unsigned DIV_NUM_W = 48;
  localparam int unsigned DIV_DEN_W = 32;
  localparam int unsigned DIV_CW    = $clog2(DIV_NUM_W + 1);

  localparam logic [2:0] MODE_LOAD_MAP   = 3'd0;
  localparam logic [2:0] MODE_LOAD_CHUNK = 3'd1;
  localparam logic [2:0] MODE_LOAD_SIZE  = 3'd2;
  localparam logic [2:0] MODE_LOAD_TIME  = 3'd3;
  localparam logic [2:0] MODE_SAMPLE_Q   = 3'd4;
  localparam logic [2:0] MODE_TIME_Q     = 3'd5;

  localparam logic [2:0] CFG_FIXED_SIZE    = 3'd0;
  localparam logic [2:0] CFG_MAP_ENTRIES   = 3'd1;
  localparam logic [2:0] CFG_CHUNK_ENTRIES = 3'd2;
  localparam logic [2:0] CFG_SIZE_ENTRIES  = 3'd3;
  localparam logic [2:0] CFG_TIME_ENTRIES  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_ERR      = 2'd2;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] dividend;
    logic [DIV_DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/mp4_sample_table_locator_unit.sv
// A load writes one table entry; a time query walks the time runs and then divides.
// A sample query walks the chunk map entries, divides, sums the size entries in the
// chunk (table mode) and walks the time runs.
// The unit takes one request at a time and shares one divider and the table memories
// among its steps. Reset clears the control state and the configuration registers only;
// table memories keep their contents and must be loaded before use.
`include "mp4_sample_table_locator_unit_macros.svh"

module mp4_sample_table_locator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [11:0] entry_index_i,
  input  logic [31:0] word_a_i,
  input  logic [31:0] word_b_i,
  input  logic [31:0] sample_number_i,
  input  logic [47:0] time_position_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] byte_offset_o,
  output logic [31:0] byte_size_o,
  output logic [47:0] timestamp_o,
  output logic [31:0] found_sample_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Sequencer states. Most of them issue a memory read, consume the read data of the
  // previous cycle, use the registered product, or wait for the shared divider.
  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_M0     = 18'h00002,
    S_MCHK   = 18'h00004,
    S_MCMP   = 18'h00008,
    S_SEL    = 18'h00010,
    S_SDIV   = 18'h00020,
    S_OFFWT  = 18'h00040,
    S_SIZE   = 18'h00080,
    S_FIXCHK = 18'h00100,
    S_SZACC  = 18'h00200,
    S_SZLAST = 18'h00400,
    S_TSTART = 18'h00800,
    S_TCHK   = 18'h01000,
    S_TACC   = 18'h02000,
    S_QCHK   = 18'h04000,
    S_QCMP   = 18'h08000,
    S_QDIV   = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] fixed_q;
  logic [6:0]  map_ent_q;
  logic [10:0] chunk_ent_q;
  logic [12:0] size_ent_q;
  logic [6:0]  time_ent_q;

  // Pair memory: chunk map entries in the lower part, time runs above them.
  // Word memory: sample sizes in the lower part, chunk offsets above them.
  logic [63:0] pair_mem [mp4stl_pkg::PAIR_DEPTH];
  logic [31:0] word_mem [mp4stl_pkg::WORD_DEPTH];
  logic [63:0] pair_rd_q;
  logic [31:0] word_rd_q;

  logic                           pair_we, pair_re, word_we, word_re;
  logic [mp4stl_pkg::PAIR_AW-1:0] pair_wa, pair_ra;
  logic [mp4stl_pkg::WORD_AW-1:0] word_wa, word_ra;
  logic [63:0]                    pair_wd;
  logic [31:0]                    word_wd;

  // Working registers of the request in flight.
  logic [31:0]                    s_q, s_d;
  logic [47:0]                    t_q, t_d;
  logic [mp4stl_pkg::LOOP_IW-1:0] i_q, i_d;
  logic [31:0]                    cur_first_q, cur_first_d, cur_spc_q, cur_spc_d;
  logic [31:0]                    nxt_first_q, nxt_first_d, nxt_spc_q, nxt_spc_d;
  logic [47:0]                    ntotal_q, ntotal_d;
  logic [38:0]                    before_q, before_d;
  logic [48:0]                    pos_q, pos_d;
  logic [48:0]                    off_q, off_d;
  logic [31:0]                    k_q, k_d;
  logic [31:0]                    rem_q, rem_d;
  logic [31:0]                    cnt_q, cnt_d;
  logic [31:0]                    d_q, d_d;
  logic                           hit_q, hit_d;
  logic [47:0]                    res_off_q, res_off_d, res_ts_q, res_ts_d;
  logic [31:0]                    res_size_q, res_size_d, res_found_q, res_found_d;
  logic [1:0]                     res_st_q, res_st_d;

  // Output register, so a new request can be taken while a result waits.
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_off_q, out_off_d, out_ts_q, out_ts_d;
  logic [31:0] out_size_q, out_size_d, out_found_q, out_found_d;
  logic [1:0]  out_st_q, out_st_d;

  // One shared 32x32 multiplier with a registered product.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p, mul_q;

  mp4stl_pkg::div_req_t div_req;
  mp4stl_pkg::div_rsp_t div_rsp;

  // Temporaries of the sequencer.
  logic [31:0] diff_s, run_cnt, run_d, chunk_sel, qd_cnt;
  logic [47:0] diff_t;
  logic [32:0] chunk_ix;
  logic [48:0] off_sum, found_sum;
  logic        run_hit;

  assign mul_p = mul_a * mul_b;

  mp4stl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    s_d         = s_q;
    t_d         = t_q;
    i_d         = i_q;
    cur_first_d = cur_first_q;
    cur_spc_d   = cur_spc_q;
    nxt_first_d = nxt_first_q;
    nxt_spc_d   = nxt_spc_q;
    ntotal_d    = ntotal_q;
    before_d    = before_q;
    pos_d       = pos_q;
    off_d       = off_q;
    k_d         = k_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    d_d         = d_q;
    hit_d       = hit_q;
    res_off_d   = res_off_q;
    res_ts_d    = res_ts_q;
    res_size_d  = res_size_q;
    res_found_d = res_found_q;
    res_st_d    = res_st_q;

    out_valid_d = out_valid_q && out_stall_i;
    out_off_d   = out_off_q;
    out_ts_d    = out_ts_q;
    out_size_d  = out_size_q;
    out_found_d = out_found_q;
    out_st_d    = out_st_q;

    pair_we = 1'b0;
    pair_wa = '0;
    pair_wd = {word_b_i, word_a_i};
    pair_re = 1'b0;
    pair_ra = '0;
    word_we = 1'b0;
    word_wa = '0;
    word_wd = word_a_i;
    word_re = 1'b0;
    word_ra = '0;
    mul_a   = '0;
    mul_b   = '0;
    div_req = '0;

    diff_s    = s_q - ntotal_q[31:0];
    diff_t    = t_q - ntotal_q;
    run_cnt   = pair_rd_q[31:0];
    run_d     = pair_rd_q[63:32];
    chunk_ix  = 33'(cur_first_q) - 33'd1 + 33'(div_rsp.quot[31:0]);
    chunk_sel = (chunk_ix < 33'(chunk_ent_q)) ? chunk_ix[31:0]
                                               : 32'(chunk_ent_q) - 32'd1;
    off_sum   = off_q + 49'(word_rd_q);
    found_sum = 49'(before_q) + 49'(div_rsp.quot);
    qd_cnt    = s_q - before_q[31:0];
    run_hit   = qd_cnt < run_cnt;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          s_d         = sample_number_i;
          t_d         = time_position_i;
          res_off_d   = '0;
          res_ts_d    = '0;
          res_size_d  = '0;
          res_found_d = '0;
          res_st_d    = mp4stl_pkg::ST_OK;
          i_d         = '0;
          ntotal_d    = '0;
          before_d    = '0;
          state_d     = S_FIN;
          case (mode_i)
            mp4stl_pkg::MODE_LOAD_MAP: begin
              if (32'(entry_index_i) < mp4stl_pkg::MAP_DEPTH) begin
                pair_we = 1'b1;
                pair_wa = mp4stl_pkg::PAIR_AW'(entry_index_i);
              end else begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end
            end
            mp4stl_pkg::MODE_LOAD_TIME: begin
              if (32'(entry_index_i) < mp4stl_pkg::TIME_DEPTH) begin
                pair_we = 1'b1;
                pair_wa = mp4stl_pkg::PAIR_AW'(mp4stl_pkg::MAP_DEPTH + 32'(entry_index_i));
              end else begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end
            end
            mp4stl_pkg::MODE_LOAD_SIZE: begin
              if (32'(entry_index_i) < mp4stl_pkg::SIZE_DEPTH) begin
                word_we = 1'b1;
                word_wa = mp4stl_pkg::WORD_AW'(entry_index_i);
              end else begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end
            end
            mp4stl_pkg::MODE_LOAD_CHUNK: begin
              if (32'(entry_index_i) < mp4stl_pkg::CHUNK_DEPTH) begin
                word_we = 1'b1;
                word_wa = mp4stl_pkg::WORD_AW'(mp4stl_pkg::SIZE_DEPTH + 32'(entry_index_i));
              end else begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end
            end
            mp4stl_pkg::MODE_SAMPLE_Q: begin
              if (map_ent_q == '0 || 32'(map_ent_q) > mp4stl_pkg::MAP_DEPTH ||
                  32'(chunk_ent_q) > mp4stl_pkg::CHUNK_DEPTH ||
                  32'(time_ent_q) > mp4stl_pkg::TIME_DEPTH) begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end else begin
                pair_re = 1'b1;
                pair_ra = '0;
                state_d = S_M0;
              end
            end
            mp4stl_pkg::MODE_TIME_Q: begin
              if (32'(time_ent_q) > mp4stl_pkg::TIME_DEPTH) begin
                res_st_d = mp4stl_pkg::ST_ERR;
              end else if (time_ent_q == '0) begin
                res_st_d = mp4stl_pkg::ST_NOTFOUND;
              end else begin
                pair_re = 1'b1;
                pair_ra = mp4stl_pkg::PAIR_AW'(mp4stl_pkg::MAP_DEPTH);
                state_d = S_QCHK;
              end
            end
            default: begin
              res_st_d = mp4stl_pkg::ST_ERR;
            end
          endcase
        end
      end

      S_M0: begin
        cur_first_d = pair_rd_q[31:0];
        cur_spc_d   = pair_rd_q[63:32];
        if (map_ent_q == 7'd1) begin
          state_d = S_SEL;
        end else begin
          pair_re = 1'b1;
          pair_ra = mp4stl_pkg::PAIR_AW'(1);
          state_d = S_MCHK;
        end
      end

      S_MCHK: begin
        nxt_first_d = pair_rd_q[31:0];
        nxt_spc_d   = pair_rd_q[63:32];
        if (pair_rd_q[31:0] < cur_first_q) begin
          res_st_d = mp4stl_pkg::ST_ERR;
          state_d  = S_FIN;
        end else begin
          mul_a   = pair_rd_q[31:0] - cur_first_q;
          mul_b   = cur_spc_q;
          state_d = S_MCMP;
        end
      end

      S_MCMP: begin
        if (64'(diff_s) < mul_q) begin
          state_d = S_SEL;
        end else begin
          ntotal_d    = ntotal_q + mul_q[47:0];
          cur_first_d = nxt_first_q;
          cur_spc_d   = nxt_spc_q;
          i_d         = i_q + 1'b1;
          if (32'(i_q) + 32'd2 < 32'(map_ent_q)) begin
            pair_re = 1'b1;
            pair_ra = mp4stl_pkg::PAIR_AW'(32'(i_q) + 32'd2);
            state_d = S_MCHK;
          end else begin
            state_d = S_SEL;
          end
        end
      end

      S_SEL: begin
        if (cur_first_q == '0 || cur_spc_q == '0) begin
          res_st_d = mp4stl_pkg::ST_ERR;
          state_d  = S_FIN;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = 48'(diff_s);
          div_req.divisor  = cur_spc_q;
          state_d          = S_SDIV;
        end
      end

      S_SDIV: begin
        if (div_rsp.done) begin
          // The first sample of the chunk is the sample less its position in it.
          rem_d = div_rsp.rem;
          k_d   = s_q - div_rsp.rem;
          if (chunk_ent_q == '0) begin
            off_d   = 49'(mp4stl_pkg::BASE_OFFSET);
            state_d = S_SIZE;
          end else begin
            word_re = 1'b1;
            word_ra = mp4stl_pkg::WORD_AW'(mp4stl_pkg::SIZE_DEPTH + chunk_sel);
            state_d = S_OFFWT;
          end
        end
      end

      S_OFFWT: begin
        off_d   = 49'(word_rd_q);
        state_d = S_SIZE;
      end

      S_SIZE: begin
        if (fixed_q != '0) begin
          mul_a   = rem_q;
          mul_b   = fixed_q;
          state_d = S_FIXCHK;
        end else if (32'(size_ent_q) > mp4stl_pkg::SIZE_DEPTH ||
                     s_q >= 32'(size_ent_q)) begin
          res_st_d = mp4stl_pkg::ST_ERR;
          state_d  = S_FIN;
        end else begin
          word_re = 1'b1;
          if (k_q < s_q) begin
            word_ra = mp4stl_pkg::WORD_AW'(k_q);
            state_d = S_SZACC;
          end else begin
            word_ra = mp4stl_pkg::WORD_AW'(s_q);
            state_d = S_SZLAST;
          end
        end
      end

      S_FIXCHK: begin
        if (mul_q > 64'(mp4stl_pkg::MAX48) - 64'(off_q)) begin
          res_st_d = mp4stl_pkg::ST_ERR;
          state_d  = S_FIN;
        end else begin
          off_d      = off_q + 49'(mul_q[47:0]);
          res_size_d = fixed_q;
          state_d    = S_TSTART;
        end
      end

      S_SZACC: begin
        // One size entry is summed per cycle while the next one is read.
        if (off_sum > 49'(mp4stl_pkg::MAX48)) begin
          res_st_d = mp4stl_pkg::ST_ERR;
          state_d  = S_FIN;
        end else begin
          off_d   = off_sum;
          k_d     = k_q + 32'd1;
          word_re = 1'b1;
          if (k_q + 32'd1 < s_q) begin
            word_ra = mp4stl_pkg::WORD_AW'(k_q + 32'd1);
          end else begin
            word_ra = mp4stl_pkg::WORD_AW'(s_q);
            state_d = S_SZLAST;
          end
        end
      end

      S_SZLAST: begin
        res_size_d = word_rd_q;
        state_d    = S_TSTART;
      end

      S_TSTART: begin
        res_off_d = off_q[47:0];
        i_d       = '0;
        pos_d     = '0;
        before_d  = '0;
        if (time_ent_q == '0) begin
          state_d = S_FIN;
        end else begin
          pair_re = 1'b1;
          pair_ra = mp4stl_pkg::PAIR_AW'(mp4stl_pkg::MAP_DEPTH);
          state_d = S_TCHK;
        end
      end

      S_TCHK: begin
        cnt_d   = run_cnt;
        hit_d   = run_hit;
        mul_a   = run_d;
        mul_b   = run_hit ? qd_cnt : run_cnt;
        state_d = S_TACC;
      end

      S_TACC: begin
        if (hit_q) begin
          if (pos_q > 49'(mp4stl_pkg::MAX48) ||
              mul_q > 64'(mp4stl_pkg::MAX48) - 64'(pos_q)) begin
            res_st_d = mp4stl_pkg::ST_ERR;
          end else begin
            res_ts_d = pos_q[47:0] + mul_q[47:0];
          end
          state_d = S_FIN;
        end else begin
          // Past 48 bits the running time saturates one above the limit.
          if (pos_q <= 49'(mp4stl_pkg::MAX48)) begin
            pos_d = (mul_q > 64'(mp4stl_pkg::MAX48) - 64'(pos_q))
                  ? 49'(mp4stl_pkg::MAX48) + 49'd1
                  : pos_q + 49'(mul_q[47:0]);
          end
          before_d = before_q + 39'(cnt_q);
          i_d      = i_q + 1'b1;
          if (32'(i_q) + 32'd1 < 32'(time_ent_q)) begin
            pair_re = 1'b1;
            pair_ra = mp4stl_pkg::PAIR_AW'(mp4stl_pkg::MAP_DEPTH + 32'(i_q) + 32'd1);
            state_d = S_TCHK;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_QCHK: begin
        cnt_d   = run_cnt;
        d_d     = run_d;
        mul_a   = run_cnt;
        mul_b   = run_d;
        state_d = S_QCMP;
      end

      S_QCMP: begin
        if (64'(diff_t) < mul_q) begin
          div_req.start    = 1'b1;
          div_req.dividend = diff_t;
          div_req.divisor  = d_q;
          state_d          = S_QDIV;
        end else begin
          ntotal_d = ntotal_q + mul_q[47:0];
          before_d = before_q + 39'(cnt_q);
          i_d      = i_q + 1'b1;
          if (32'(i_q) + 32'd1 < 32'(time_ent_q)) begin
            pair_re = 1'b1;
            pair_ra = mp4stl_pkg::PAIR_AW'(mp4stl_pkg::MAP_DEPTH + 32'(i_q) + 32'd1);
            state_d = S_QCHK;
          end else begin
            res_st_d = mp4stl_pkg::ST_NOTFOUND;
            state_d  = S_FIN;
          end
        end
      end

      S_QDIV: begin
        if (div_rsp.done) begin
          if (found_sum > 49'(32'hFFFF_FFFF)) begin
            res_st_d = mp4stl_pkg::ST_ERR;
          end else begin
            res_found_d = found_sum[31:0];
          end
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // Any failure clears every answer field.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          if (res_st_q == mp4stl_pkg::ST_OK) begin
            out_off_d   = res_off_q;
            out_ts_d    = res_ts_q;
            out_size_d  = res_size_q;
            out_found_d = res_found_q;
          end else begin
            out_off_d   = '0;
            out_ts_d    = '0;
            out_size_d  = '0;
            out_found_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      fixed_q     <= '0;
      map_ent_q   <= '0;
      chunk_ent_q <= '0;
      size_ent_q  <= '0;
      time_ent_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          mp4stl_pkg::CFG_FIXED_SIZE:    fixed_q     <= cfg_data_i;
          mp4stl_pkg::CFG_MAP_ENTRIES:   map_ent_q   <= cfg_data_i[6:0];
          mp4stl_pkg::CFG_CHUNK_ENTRIES: chunk_ent_q <= cfg_data_i[10:0];
          mp4stl_pkg::CFG_SIZE_ENTRIES:  size_ent_q  <= cfg_data_i[12:0];
          mp4stl_pkg::CFG_TIME_ENTRIES:  time_ent_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    t_q         <= t_d;
    i_q         <= i_d;
    cur_first_q <= cur_first_d;
    cur_spc_q   <= cur_spc_d;
    nxt_first_q <= nxt_first_d;
    nxt_spc_q   <= nxt_spc_d;
    ntotal_q    <= ntotal_d;
    before_q    <= before_d;
    pos_q       <= pos_d;
    off_q       <= off_d;
    k_q         <= k_d;
    rem_q       <= rem_d;
    cnt_q       <= cnt_d;
    d_q         <= d_d;
    hit_q       <= hit_d;
    res_off_q   <= res_off_d;
    res_ts_q    <= res_ts_d;
    res_size_q  <= res_size_d;
    res_found_q <= res_found_d;
    res_st_q    <= res_st_d;
    out_off_q   <= out_off_d;
    out_ts_q    <= out_ts_d;
    out_size_q  <= out_size_d;
    out_found_q <= out_found_d;
    out_st_q    <= out_st_d;
    mul_q       <= mul_p;
  end

  // Table memories: one write or one registered read per cycle each.
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_mem[pair_wa] <= pair_wd;
    end
    if (pair_re) begin
      pair_rd_q <= pair_mem[pair_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_mem[word_wa] <= word_wd;
    end
    if (word_re) begin
      word_rd_q <= word_mem[word_ra];
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign byte_offset_o  = out_off_q;
  assign byte_size_o    = out_size_q;
  assign timestamp_o    = out_ts_q;
  assign found_sample_o = out_found_q;
  assign status_o       = out_st_q;

  `MP4STL_ASSERT_NXT(a_accept_goes_busy, in_valid_i && !in_stall_o, in_stall_o)
  `MP4STL_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_q))
  `MP4STL_ASSERT_IMP(a_div_only_when_waited, div_rsp.busy, state_q == S_SDIV || state_q == S_QDIV)
  `MP4STL_ASSERT_IMP(a_err_clears_fields, out_valid_o && status_o == mp4stl_pkg::ST_ERR, byte_offset_o == '0 && byte_size_o == '0 && found_sample_o == '0)

endmodule

FILE: rtl/mp4stl_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module mp4stl_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mp4stl_pkg::div_req_t req_i,
  output mp4stl_pkg::div_rsp_t rsp_o
);

  logic                             busy_q, busy_d;
  logic [mp4stl_pkg::DIV_CW-1:0]    cnt_q, cnt_d;
  logic [mp4stl_pkg::DIV_NUM_W-1:0] quot_q, quot_d;
  logic [mp4stl_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [mp4stl_pkg::DIV_DEN_W-1:0] den_q, den_d;
  logic [mp4stl_pkg::DIV_DEN_W:0]   trial;
  logic                             last;

  assign last  = (cnt_q == mp4stl_pkg::DIV_CW'(mp4stl_pkg::DIV_NUM_W));
  assign trial = {rem_q, quot_q[mp4stl_pkg::DIV_NUM_W-1]};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
    end else if (busy_q) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        if (trial >= {1'b0, den_q}) begin
          rem_d  = mp4stl_pkg::DIV_DEN_W'(trial - {1'b0, den_q});
          quot_d = {quot_q[mp4stl_pkg::DIV_NUM_W-2:0], 1'b1};
        end else begin
          rem_d  = trial[mp4stl_pkg::DIV_DEN_W-1:0];
          quot_d = {quot_q[mp4stl_pkg::DIV_NUM_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = busy_q && last;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule
